>>> rtl/core/sprd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sprite run-length line decoder.
// No dependencies; every other file of the block imports this package.
package sprd_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int BYTE_W    = 8;
   localparam int CFG_W     = 11;
   localparam int REG_IDX_W = 2;
   localparam int LEN_W     = 9;
   localparam int XS_W      = 10;
   localparam int ROW_W     = 10;

   localparam int WD_W = $clog2(MAX_WIDTH + 1);
   localparam int XP_W = $clog2(MAX_WIDTH);
   localparam int HT_W = $clog2(MAX_HEIGHT + 1);
   localparam int YP_W = $clog2(MAX_HEIGHT);
   localparam int RM_W = (WD_W > LEN_W) ? WD_W : LEN_W;

   localparam logic [REG_IDX_W-1:0] REG_PIX_FORMAT = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_LINE_COUNT = 2'd2;

   localparam logic [1:0] FMT_RAW  = 2'd0;
   localparam logic [1:0] FMT_PAIR = 2'd1;

   localparam logic [BYTE_W-1:0] RAW_CODE_PAIR   = 8'hFF;
   localparam logic [2:0]        RAW_CODE_PACKED = 3'd7;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LENGTH = 2'd1,
      PH_RAW    = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type         phase;
      logic [BYTE_W-1:0] held_code;
      logic [LEN_W-1:0]  raw_left;
      logic [LEN_W-1:0]  seg_left;
      logic [XP_W-1:0]   x_pos;
      logic [YP_W-1:0]   row_pos;
   } state_type;

   localparam state_type STATE_CLEAR = '{
      phase:     PH_HEADER,
      held_code: '0,
      raw_left:  '0,
      seg_left:  '0,
      x_pos:     '0,
      row_pos:   '0
   };

   typedef struct packed {
      logic [1:0]      fmt;
      logic [WD_W-1:0] width;
      logic [HT_W-1:0] count;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel_index;
      logic [LEN_W-1:0]  run_length;
      logic [XS_W-1:0]   x_start;
      logic [ROW_W-1:0]  row_number;
      logic              line_last;
      logic              frame_last;
      logic              overrun;
   } result_type;

endpackage

>>> rtl/core/sprd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the decoder: byte input, run output, register writes.
// Depends on sprd_pkg.
interface sprd_req_if;
   import sprd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface sprd_rsp_if;
   import sprd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] pixel_index;
   logic [LEN_W-1:0]  run_length;
   logic [XS_W-1:0]   x_start;
   logic [ROW_W-1:0]  row_number;
   logic              line_last;
   logic              frame_last;
   logic              overrun;
   modport source (output valid, output pixel_index, output run_length, output x_start,
                   output row_number, output line_last, output frame_last,
                   output overrun, input ready);
   modport sink (input valid, input pixel_index, input run_length, input x_start,
                 input row_number, input line_last, input frame_last,
                 input overrun, output ready);
endinterface

interface sprd_csr_if;
   import sprd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [REG_IDX_W-1:0] index;
   logic [CFG_W-1:0]     wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/core/sprd_csr.sv
`timescale 1ns / 1ps
// Configuration registers: format, clamped line width and line count.
// Depends on sprd_pkg and sprd_csr_if.
module sprd_csr (
   input  logic             clock,
   input  logic             reset,
   sprd_csr_if.sink         csr_chan,
   output logic             clear,
   output sprd_pkg::cfg_type cfg
);
   import sprd_pkg::*;

   cfg_type         cfg_ff;
   cfg_type         cfg_in;
   logic            wr;
   logic [WD_W-1:0] width_clamp;
   logic [HT_W-1:0] count_clamp;

   assign csr_chan.ready = 1'b1;
   assign wr = csr_chan.valid && csr_chan.ready;

   always_comb begin
      if (csr_chan.wdata == '0) begin
         width_clamp = WD_W'(1);
      end else if (int'(csr_chan.wdata) > MAX_WIDTH) begin
         width_clamp = WD_W'(MAX_WIDTH);
      end else begin
         width_clamp = WD_W'(csr_chan.wdata);
      end
      if (csr_chan.wdata == '0) begin
         count_clamp = HT_W'(1);
      end else if (int'(csr_chan.wdata) > MAX_HEIGHT) begin
         count_clamp = HT_W'(MAX_HEIGHT);
      end else begin
         count_clamp = HT_W'(csr_chan.wdata);
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      clear  = 1'b0;
      if (wr) begin
         unique case (csr_chan.index)
            REG_PIX_FORMAT: begin
               cfg_in.fmt = csr_chan.wdata[1:0];
               clear      = 1'b1;
            end
            REG_LINE_WIDTH: begin
               cfg_in.width = width_clamp;
               clear        = 1'b1;
            end
            REG_LINE_COUNT: begin
               cfg_in.count = count_clamp;
               clear        = 1'b1;
            end
            default: begin
               cfg_in = cfg_ff;
               clear  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fmt   <= FMT_RAW;
         cfg_ff.width <= WD_W'(1);
         cfg_ff.count <= HT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/sprd_step.sv
`timescale 1ns / 1ps
// Per-byte decode: segment header parsing, run clipping and column/row advance.
// Purely combinational; depends on sprd_pkg.
module sprd_step (
   input  sprd_pkg::state_type       cur,
   input  sprd_pkg::cfg_type         cfg,
   input  logic [sprd_pkg::BYTE_W-1:0] data_byte,
   output sprd_pkg::state_type       nxt,
   output logic                      fire,
   output sprd_pkg::result_type      res
);
   import sprd_pkg::*;

   logic [RM_W-1:0]   room;
   logic [LEN_W-1:0]  len;
   logic [LEN_W-1:0]  n;
   logic [BYTE_W-1:0] color;
   logic              clip;
   logic              raw_go;
   logic              fill_go;
   logic [RM_W-1:0]   x_sum;
   logic [HT_W-1:0]   row_sum;

   always_comb begin
      nxt     = cur;
      fire    = 1'b0;
      color   = data_byte;
      n       = LEN_W'(1);
      clip    = 1'b0;
      raw_go  = 1'b0;
      fill_go = 1'b0;
      len     = LEN_W'(data_byte) + LEN_W'(1);
      room    = RM_W'(cfg.width) - RM_W'(cur.x_pos);
      res     = '0;
      x_sum   = '0;
      row_sum = '0;

      unique case (cur.phase)
         PH_RAW: begin
            if (cur.raw_left != '0) begin
               nxt.raw_left = cur.raw_left - LEN_W'(1);
               fire         = 1'b1;
            end else if (cur.seg_left != '0) begin
               nxt.seg_left = cur.seg_left - LEN_W'(1);
            end
            if ((nxt.raw_left | nxt.seg_left) == '0) begin
               nxt.phase = PH_HEADER;
            end
         end
         PH_LENGTH: begin
            nxt.phase = PH_HEADER;
            if (cur.held_code == RAW_CODE_PAIR) begin
               raw_go = 1'b1;
            end else begin
               fill_go = 1'b1;
               color   = cur.held_code;
            end
         end
         default: begin
            nxt.phase = PH_HEADER;
            case (cfg.fmt)
               FMT_RAW: begin
                  fire = 1'b1;
               end
               FMT_PAIR: begin
                  nxt.held_code = data_byte;
                  nxt.phase     = PH_LENGTH;
               end
               default: begin
                  nxt.held_code = BYTE_W'(data_byte[7:5]);
                  len           = LEN_W'(data_byte[4:0]) + LEN_W'(1);
                  color         = BYTE_W'(data_byte[7:5]);
                  if (data_byte[7:5] == RAW_CODE_PACKED) begin
                     raw_go = 1'b1;
                  end else begin
                     fill_go = 1'b1;
                  end
               end
            endcase
         end
      endcase

      if (raw_go) begin
         nxt.phase = PH_RAW;
         if (RM_W'(len) > room) begin
            nxt.raw_left = LEN_W'(room);
            nxt.seg_left = len - LEN_W'(room);
         end else begin
            nxt.raw_left = len;
            nxt.seg_left = '0;
         end
      end

      if (fill_go) begin
         fire = 1'b1;
         if (RM_W'(len) > room) begin
            n    = LEN_W'(room);
            clip = 1'b1;
         end else begin
            n = len;
         end
      end

      if (fire) begin
         res.pixel_index = color;
         res.run_length  = n;
         res.x_start     = XS_W'(cur.x_pos);
         res.row_number  = ROW_W'(cur.row_pos);
         res.overrun     = clip;
         x_sum           = RM_W'(cur.x_pos) + RM_W'(n);
         if (x_sum >= RM_W'(cfg.width)) begin
            res.line_last = 1'b1;
            nxt.x_pos     = '0;
            row_sum       = HT_W'(cur.row_pos) + HT_W'(1);
            if (row_sum >= cfg.count) begin
               res.frame_last = 1'b1;
               nxt.row_pos    = '0;
            end else begin
               nxt.row_pos = YP_W'(row_sum);
            end
         end else begin
            nxt.x_pos = XP_W'(x_sum);
         end
      end
   end

endmodule

>>> rtl/core/sprite_rle_line_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the sprite run-length line decoder.
// Depends on sprd_pkg, sprd_if, sprd_csr and sprd_step.
//
// Usage:
//   req_chan carries one byte of sprite pixel data per transfer. rsp_chan
//   carries one run (palette index, length, column, row, line/frame end and
//   clip flags). Header bytes, raw-segment headers and raw bytes dropped past
//   the line end produce no run. csr_chan writes pix_format (0), line_width
//   (1) and line_count (2); any write to one of them rewinds the decoder to
//   column 0, row 0, expecting a header. Write only while no run is pending.
// Timing:
//   One byte per clock while the output is not stalled. A run appears on
//   rsp_chan in the cycle after the byte that causes it; the decode is one
//   pass of logic between the decoder state and the output register.
// Reset:
//   Format 0, width 1, count 1, position cleared. No clearing pass.
// Stall:
//   The output register holds its run while rsp_chan.ready is low. A new byte
//   is taken whenever the output register is empty or drains in that cycle.
module sprite_rle_line_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   sprd_req_if.sink   req_chan,
   sprd_rsp_if.source rsp_chan,
   sprd_csr_if.sink   csr_chan
);
   import sprd_pkg::*;

   cfg_type    cfg;
   logic       cfg_clear;
   state_type  state_ff;
   state_type  state_in;
   logic       step_fire;
   result_type step_res;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   logic       accept;

   sprd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .clear    (cfg_clear),
      .cfg      (cfg)
   );

   sprd_step u_step (
      .cur       (state_ff),
      .cfg       (cfg),
      .data_byte (req_chan.data_byte),
      .nxt       (state_in),
      .fire      (step_fire),
      .res       (step_res)
   );

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (accept && step_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_clear) begin
            state_ff <= STATE_CLEAR;
         end else if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_fire) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_index = rsp_ff.pixel_index;
   assign rsp_chan.run_length  = rsp_ff.run_length;
   assign rsp_chan.x_start     = rsp_ff.x_start;
   assign rsp_chan.row_number  = rsp_ff.row_number;
   assign rsp_chan.line_last   = rsp_ff.line_last;
   assign rsp_chan.frame_last  = rsp_ff.frame_last;
   assign rsp_chan.overrun     = rsp_ff.overrun;

   a_raw_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_RAW |-> (state_ff.raw_left != '0 || state_ff.seg_left != '0))
      else $error("raw phase with nothing left to take");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      WD_W'(state_ff.x_pos) < cfg.width)
      else $error("column beyond line width");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      HT_W'(state_ff.row_pos) < cfg.count)
      else $error("row beyond line count");

   a_frame_ends_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_last |-> rsp_ff.line_last)
      else $error("frame end without line end");

   a_clip_ends_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.overrun |-> rsp_ff.line_last)
      else $error("clipped run does not end the line");

endmodule
